### sv/gbhe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbhe_pkg
// shared types, codes and defaults for the byte handshake engine
// ----------------------------------------------------------------------------
package gbhe_pkg;

  localparam int RING_DEPTH_DEF = 16;

  localparam logic [2:0] ACT_SAMPLE    = 3'd0;
  localparam logic [2:0] ACT_PUSH      = 3'd1;
  localparam logic [2:0] ACT_PUSH_LAST = 3'd2;
  localparam logic [2:0] ACT_POP       = 3'd3;
  localparam logic [2:0] ACT_TALK      = 3'd4;
  localparam logic [2:0] ACT_LISTEN    = 3'd5;
  localparam logic [2:0] ACT_PASSIVE   = 3'd6;
  localparam logic [2:0] ACT_CLR_END   = 3'd7;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_TX_FULL  = 3'd1;
  localparam logic [2:0] ST_RX_EMPTY = 3'd2;
  localparam logic [2:0] ST_BUSY     = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  localparam logic [1:0] MODE_PASSIVE = 2'd0;
  localparam logic [1:0] MODE_TX      = 2'd1;
  localparam logic [1:0] MODE_RX      = 2'd2;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] tx_byte;
    logic       nrfd_line;
    logic       ndac_line;
    logic       dav_line;
    logic       eoi_line;
    logic [7:0] data_line;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] rx_byte;
    logic       end_seen;
    logic       dav_drive;
    logic       nrfd_drive;
    logic       ndac_drive;
    logic       eoi_drive;
    logic [7:0] data_drive;
    logic       talking;
    logic       tx_done;
    logic       rx_available;
    logic [1:0] mode;
  } out_item_t;

  // classified operation handed from front to back
  typedef struct packed {
    logic is_sample;
    logic is_push;
    logic is_last;
    logic is_pop;
    logic is_talk;
    logic is_listen;
    logic is_passive;
    logic is_clr_end;
  } op_class_t;

  typedef struct packed {
    op_class_t cls;
    in_item_t  item;
  } queue_entry_t;

endpackage

### sv/gbhe_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbhe_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module gbhe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = gbhe_pkg::RING_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/gbhe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbhe_front
// accepts items, classifies the action and queues them for the engine
// ----------------------------------------------------------------------------
module gbhe_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  gbhe_pkg::in_item_t      in_item,
  output logic                    q_valid,
  output gbhe_pkg::queue_entry_t  q_head,
  input  logic                    q_take
);

  gbhe_pkg::queue_entry_t slot [2];
  gbhe_pkg::queue_entry_t new_entry;
  logic [1:0] count;
  logic       rd_ptr;
  logic       wr_ptr;
  logic       push;

  always_comb begin
    new_entry.item = in_item;
    new_entry.cls  = '0;
    unique case (in_item.action)
      gbhe_pkg::ACT_SAMPLE:    new_entry.cls.is_sample  = 1'b1;
      gbhe_pkg::ACT_PUSH:      new_entry.cls.is_push    = 1'b1;
      gbhe_pkg::ACT_PUSH_LAST: begin
        new_entry.cls.is_push = 1'b1;
        new_entry.cls.is_last = 1'b1;
      end
      gbhe_pkg::ACT_POP:       new_entry.cls.is_pop     = 1'b1;
      gbhe_pkg::ACT_TALK:      new_entry.cls.is_talk    = 1'b1;
      gbhe_pkg::ACT_LISTEN:    new_entry.cls.is_listen  = 1'b1;
      gbhe_pkg::ACT_PASSIVE:   new_entry.cls.is_passive = 1'b1;
      default:                 new_entry.cls.is_clr_end = 1'b1;
    endcase
  end

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_head   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= new_entry;
    end
    if (rst) begin
      count  <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_take) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(q_take);
    end
  end

  a_no_take_empty: assert property (@(posedge clk) disable iff (rst)
    q_take |-> q_valid) else $error("take from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("queue count out of range");
  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2 && !q_take) |=> in_stall) else $error("full queue not stalled");

endmodule

### sv/gbhe_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbhe_engine
// carries out queued items: rings, talker and listener handshakes, result reg
// ----------------------------------------------------------------------------
module gbhe_engine #(
  parameter int RING_DEPTH = gbhe_pkg::RING_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  gbhe_pkg::queue_entry_t q_head,
  output logic                   q_take,
  output logic                   out_valid,
  input  logic                   out_stall,
  output gbhe_pkg::out_item_t    out_item
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(RING_DEPTH - 1);

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
    ring_next = (i == LAST_IDX) ? '0 : i + AW'(1);
  endfunction

  logic [1:0]    mode, mode_next;
  logic [AW-1:0] tx_wi, tx_wi_next, tx_ri, tx_ri_next;
  logic          tx_end_pending, tx_end_pending_next;
  logic          tx_running, tx_running_next;
  logic          tx_await_ready, tx_await_ready_next;
  logic          tx_watch_accept, tx_watch_accept_next;
  logic [AW-1:0] rx_wi, rx_wi_next, rx_ri, rx_ri_next;
  logic          rx_end_flag, rx_end_flag_next;
  logic          rx_running, rx_running_next;
  logic          rx_await_release, rx_await_release_next;
  logic          drv_dav, drv_dav_next, drv_nrfd, drv_nrfd_next;
  logic          drv_ndac, drv_ndac_next, drv_eoi, drv_eoi_next;
  logic [7:0]    drv_data, drv_data_next;
  logic [2:0]    prev, prev_next;

  logic          tx_we, rx_we;
  logic [7:0]    tx_ram_q, rx_ram_q, tx_head, rx_head;
  logic          tx_byp, rx_byp;
  logic [7:0]    tx_byp_data, rx_byp_data;
  logic          fire;
  logic          send, send_push;
  logic [7:0]    send_byte;
  logic [2:0]    status;
  logic [7:0]    rxb;
  logic          end_out;
  gbhe_pkg::in_item_t  it;
  gbhe_pkg::op_class_t cls;
  gbhe_pkg::out_item_t res;

  assign it      = q_head.item;
  assign cls     = q_head.cls;
  assign fire    = q_valid && (!out_valid || !out_stall);
  assign q_take  = fire;
  assign tx_head = tx_byp ? tx_byp_data : tx_ram_q;
  assign rx_head = rx_byp ? rx_byp_data : rx_ram_q;

  always_comb begin
    mode_next             = mode;
    tx_wi_next            = tx_wi;
    tx_ri_next            = tx_ri;
    tx_end_pending_next   = tx_end_pending;
    tx_running_next       = tx_running;
    tx_await_ready_next   = tx_await_ready;
    tx_watch_accept_next  = tx_watch_accept;
    rx_wi_next            = rx_wi;
    rx_ri_next            = rx_ri;
    rx_end_flag_next      = rx_end_flag;
    rx_running_next       = rx_running;
    rx_await_release_next = rx_await_release;
    drv_dav_next          = drv_dav;
    drv_nrfd_next         = drv_nrfd;
    drv_ndac_next         = drv_ndac;
    drv_eoi_next          = drv_eoi;
    drv_data_next         = drv_data;
    prev_next             = prev;
    tx_we                 = 1'b0;
    rx_we                 = 1'b0;
    send                  = 1'b0;
    send_push             = 1'b0;
    status                = gbhe_pkg::ST_OK;
    rxb                   = 8'd0;
    end_out               = rx_end_flag;

    if (fire) begin
      if (cls.is_sample) begin
        if (mode == gbhe_pkg::MODE_TX) begin
          if (tx_running) begin
            if (tx_await_ready && prev[0] && !it.nrfd_line) begin
              send = 1'b1;
            end else if (!tx_await_ready && !prev[0] && it.nrfd_line) begin
              tx_watch_accept_next = 1'b1;
            end
          end
          if (tx_watch_accept_next && prev[1] && !it.ndac_line) begin
            tx_watch_accept_next = 1'b0;
            tx_await_ready_next  = 1'b1;
            drv_dav_next         = 1'b0;
          end
        end else if (mode == gbhe_pkg::MODE_RX) begin
          if (!prev[2] && it.dav_line && !rx_await_release) begin
            if (drv_nrfd) begin
              // data arrived before we were ready
              status          = gbhe_pkg::ST_OVERFLOW;
              rx_running_next = 1'b0;
            end else if (rx_running) begin
              drv_nrfd_next         = 1'b1;
              rx_await_release_next = 1'b1;
              rx_we                 = 1'b1;
              if (it.eoi_line) begin
                rx_end_flag_next = 1'b1;
              end
              drv_ndac_next = 1'b0;
            end
          end else if (prev[2] && !it.dav_line && rx_await_release) begin
            rx_await_release_next = 1'b0;
            drv_ndac_next         = 1'b1;
            if (ring_next(rx_wi) == rx_ri) begin
              rx_running_next = 1'b0;
            end else begin
              rx_wi_next    = ring_next(rx_wi);
              drv_nrfd_next = 1'b0;
            end
          end
        end
        prev_next = {it.dav_line, it.ndac_line, it.nrfd_line};
      end else if (cls.is_push) begin
        if (tx_end_pending || ring_next(tx_wi) == tx_ri) begin
          status = gbhe_pkg::ST_TX_FULL;
        end else begin
          tx_we = 1'b1;
          if (cls.is_last) begin
            tx_end_pending_next = 1'b1;
          end
          tx_wi_next = ring_next(tx_wi);
          if (mode == gbhe_pkg::MODE_TX && !tx_running) begin
            tx_running_next     = 1'b1;
            tx_await_ready_next = 1'b1;
            if (!prev[0]) begin
              send      = 1'b1;
              send_push = 1'b1;
            end
          end
        end
      end else if (cls.is_pop) begin
        if (rx_ri == rx_wi) begin
          status = gbhe_pkg::ST_RX_EMPTY;
        end else begin
          rxb        = rx_head;
          rx_ri_next = ring_next(rx_ri);
          if (mode == gbhe_pkg::MODE_RX && !rx_running) begin
            if (drv_nrfd) begin
              rx_wi_next = ring_next(rx_wi);
            end
            rx_running_next = 1'b1;
            drv_nrfd_next   = 1'b0;
          end
        end
      end else if (cls.is_talk) begin
        if (mode != gbhe_pkg::MODE_TX) begin
          rx_running_next       = 1'b0;
          rx_await_release_next = 1'b0;
          drv_dav_next          = 1'b0;
          drv_nrfd_next         = 1'b0;
          drv_ndac_next         = 1'b0;
          drv_eoi_next          = 1'b0;
          tx_wi_next            = '0;
          tx_ri_next            = '0;
          tx_end_pending_next   = 1'b0;
          tx_running_next       = 1'b0;
          tx_watch_accept_next  = 1'b0;
          tx_await_ready_next   = 1'b1;
          mode_next             = gbhe_pkg::MODE_TX;
        end
      end else if (cls.is_listen) begin
        if (mode != gbhe_pkg::MODE_RX) begin
          if (mode == gbhe_pkg::MODE_TX && (tx_ri != tx_wi || drv_dav)) begin
            status = gbhe_pkg::ST_BUSY;
          end else begin
            tx_running_next       = 1'b0;
            tx_watch_accept_next  = 1'b0;
            drv_ndac_next         = 1'b1;
            drv_dav_next          = 1'b0;
            drv_eoi_next          = 1'b0;
            rx_wi_next            = '0;
            rx_ri_next            = '0;
            rx_end_flag_next      = 1'b0;
            end_out               = 1'b0;
            rx_await_release_next = 1'b0;
            rx_running_next       = 1'b1;
            drv_nrfd_next         = 1'b0;
            mode_next             = gbhe_pkg::MODE_RX;
          end
        end
      end else if (cls.is_passive) begin
        tx_running_next       = 1'b0;
        tx_watch_accept_next  = 1'b0;
        rx_running_next       = 1'b0;
        rx_await_release_next = 1'b0;
        drv_nrfd_next         = 1'b1;
        drv_ndac_next         = 1'b1;
        drv_dav_next          = 1'b0;
        drv_eoi_next          = 1'b0;
        mode_next             = gbhe_pkg::MODE_PASSIVE;
      end else begin
        rx_end_flag_next = 1'b0;
      end

      if (send) begin
        // ring head, or the byte written now when the ring was empty
        send_byte = (send_push && tx_ri == tx_wi) ? it.tx_byte : tx_head;
        if (tx_ri != tx_wi_next) begin
          drv_data_next = send_byte;
          tx_ri_next    = ring_next(tx_ri);
          if (tx_end_pending_next && ring_next(tx_ri) == tx_wi_next) begin
            drv_eoi_next        = 1'b1;
            tx_end_pending_next = 1'b0;
          end
          tx_await_ready_next = 1'b0;
          drv_dav_next        = 1'b1;
        end else begin
          tx_running_next = 1'b0;
          drv_eoi_next    = 1'b0;
        end
      end else begin
        send_byte = 8'd0;
      end
    end else begin
      send_byte = 8'd0;
    end

    res.status       = status;
    res.rx_byte      = rxb;
    res.end_seen     = end_out;
    res.dav_drive    = drv_dav_next;
    res.nrfd_drive   = drv_nrfd_next;
    res.ndac_drive   = drv_ndac_next;
    res.eoi_drive    = drv_eoi_next;
    res.data_drive   = (mode_next == gbhe_pkg::MODE_TX) ? drv_data_next : 8'd0;
    res.talking      = (mode_next == gbhe_pkg::MODE_TX);
    res.tx_done      = (tx_ri_next == tx_wi_next) && !drv_dav_next;
    res.rx_available = (rx_ri_next != rx_wi_next);
    res.mode         = mode_next;
  end

  gbhe_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_wi),
    .wdata (it.tx_byte),
    .raddr (tx_ri_next),
    .rdata (tx_ram_q)
  );

  gbhe_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_wi),
    .wdata (it.data_line),
    .raddr (rx_ri_next),
    .rdata (rx_ram_q)
  );

  always_ff @(posedge clk) begin
    // forward a write that lands on the head being fetched
    tx_byp      <= tx_we && (tx_wi == tx_ri_next);
    tx_byp_data <= it.tx_byte;
    rx_byp      <= rx_we && (rx_wi == rx_ri_next);
    rx_byp_data <= it.data_line;
    if (fire) begin
      out_item <= res;
    end
    if (rst) begin
      out_valid        <= 1'b0;
      mode             <= gbhe_pkg::MODE_PASSIVE;
      tx_wi            <= '0;
      tx_ri            <= '0;
      tx_end_pending   <= 1'b0;
      tx_running       <= 1'b0;
      tx_await_ready   <= 1'b1;
      tx_watch_accept  <= 1'b0;
      rx_wi            <= '0;
      rx_ri            <= '0;
      rx_end_flag      <= 1'b0;
      rx_running       <= 1'b0;
      rx_await_release <= 1'b0;
      drv_dav          <= 1'b0;
      drv_nrfd         <= 1'b1;
      drv_ndac         <= 1'b1;
      drv_eoi          <= 1'b0;
      drv_data         <= 8'd0;
      prev             <= 3'd0;
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      mode             <= mode_next;
      tx_wi            <= tx_wi_next;
      tx_ri            <= tx_ri_next;
      tx_end_pending   <= tx_end_pending_next;
      tx_running       <= tx_running_next;
      tx_await_ready   <= tx_await_ready_next;
      tx_watch_accept  <= tx_watch_accept_next;
      rx_wi            <= rx_wi_next;
      rx_ri            <= rx_ri_next;
      rx_end_flag      <= rx_end_flag_next;
      rx_running       <= rx_running_next;
      rx_await_release <= rx_await_release_next;
      drv_dav          <= drv_dav_next;
      drv_nrfd         <= drv_nrfd_next;
      drv_ndac         <= drv_ndac_next;
      drv_eoi          <= drv_eoi_next;
      drv_data         <= drv_data_next;
      prev             <= prev_next;
    end
  end

  a_release_only_rx: assert property (@(posedge clk) disable iff (rst)
    rx_await_release |-> mode == gbhe_pkg::MODE_RX) else $error("listener active outside rx");
  a_dav_only_tx: assert property (@(posedge clk) disable iff (rst)
    drv_dav |-> mode == gbhe_pkg::MODE_TX) else $error("dav driven outside tx");
  a_talk_mode: assert property (@(posedge clk) disable iff (rst)
    (fire && cls.is_talk) |=> mode == gbhe_pkg::MODE_TX) else $error("talk not taken");
  a_out_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(out_item)) else $error("result lost");

endmodule

### sv/gpib_byte_handshake_engine_unit.sv
`timescale 1ns / 1ps
// an accepted item waits in a queue slot, then its result is registered in the engine output register
// throughput: 1 item per cycle while out_stall is low; the engine carries out each action as it takes the item
// the ring heads are prefetched from registered-read rams each cycle
// reset (rst, synchronous): passive mode, rings empty, nrfd and ndac driven
// ----------------------------------------------------------------------------
// gpib_byte_handshake_engine_unit
// ieee-488 source/acceptor byte handshake with transmit and receive rings
// ----------------------------------------------------------------------------
module gpib_byte_handshake_engine_unit #(
  parameter int RING_DEPTH = gbhe_pkg::RING_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  gbhe_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output gbhe_pkg::out_item_t out_item
);

  logic                   q_valid;
  logic                   q_take;
  gbhe_pkg::queue_entry_t q_head;

  gbhe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_take   (q_take)
  );

  gbhe_engine #(.RING_DEPTH(RING_DEPTH)) u_engine (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_take    (q_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

### tb/gbhe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbhe_checker
// watches both channels of the handshake engine, predicts every result beat
// from the accepted input beats and compares the two field by field
// ----------------------------------------------------------------------------
module gbhe_checker #(
  parameter int RING_DEPTH = gbhe_pkg::RING_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  gbhe_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_stall,
  input  gbhe_pkg::out_item_t out_item,
  output int                  errors,
  output int                  pending
);

  // predictor state
  logic [7:0] tx_ring [RING_DEPTH];
  logic [7:0] rx_ring [RING_DEPTH];
  logic [1:0] mode_q;
  int unsigned tx_wr, tx_rd, rx_wr, rx_rd;
  logic tx_end_pend, tx_run, tx_wait_rdy, tx_watch;
  logic rx_end, rx_run, rx_wait_rel;
  logic drv_dav, drv_nrfd, drv_ndac, drv_eoi;
  logic [7:0] drv_data;
  logic prev_nrfd, prev_ndac, prev_dav;

  gbhe_pkg::out_item_t expected_q[$];

  assign pending = expected_q.size();

  function automatic int unsigned ring_inc(int unsigned i);
    return (i + 1) % RING_DEPTH;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic void engine_reset();
    mode_q = gbhe_pkg::MODE_PASSIVE;
    tx_wr = 0; tx_rd = 0; rx_wr = 0; rx_rd = 0;
    tx_end_pend = 0; tx_run = 0; tx_watch = 0; tx_wait_rdy = 1;
    rx_end = 0; rx_run = 0; rx_wait_rel = 0;
    drv_dav = 0; drv_eoi = 0; drv_nrfd = 1; drv_ndac = 1; drv_data = '0;
    prev_nrfd = 0; prev_ndac = 0; prev_dav = 0;
  endfunction

  function automatic void send_next_byte();
    if (tx_rd != tx_wr) begin
      drv_data = tx_ring[tx_rd];
      tx_rd = ring_inc(tx_rd);
      if (tx_end_pend && tx_rd == tx_wr) begin
        drv_eoi = 1;
        tx_end_pend = 0;
      end
      tx_wait_rdy = 0;
      drv_dav = 1;
    end else begin
      tx_run = 0;
      drv_eoi = 0;
    end
  endfunction

  function automatic void release_talker();
    drv_nrfd = 1; drv_ndac = 1; drv_dav = 0; drv_eoi = 0;
  endfunction

  function automatic void bus_step(gbhe_pkg::in_item_t it, output logic [2:0] st);
    int unsigned nxt;
    st = gbhe_pkg::ST_OK;
    if (mode_q == gbhe_pkg::MODE_TX) begin
      if (tx_run) begin
        if (tx_wait_rdy && prev_nrfd && !it.nrfd_line) send_next_byte();
        else if (!tx_wait_rdy && !prev_nrfd && it.nrfd_line) tx_watch = 1;
      end
      if (tx_watch && prev_ndac && !it.ndac_line) begin
        tx_watch = 0;
        tx_wait_rdy = 1;
        drv_dav = 0;
      end
    end else if (mode_q == gbhe_pkg::MODE_RX) begin
      if (!prev_dav && it.dav_line && !rx_wait_rel) begin
        if (drv_nrfd) begin
          st = gbhe_pkg::ST_OVERFLOW;
          rx_run = 0;
        end else if (rx_run) begin
          drv_nrfd = 1;
          rx_wait_rel = 1;
          rx_ring[rx_wr] = it.data_line;
          if (it.eoi_line) rx_end = 1;
          drv_ndac = 0;
        end
      end else if (prev_dav && !it.dav_line && rx_wait_rel) begin
        nxt = ring_inc(rx_wr);
        rx_wait_rel = 0;
        drv_ndac = 1;
        if (nxt == rx_rd) rx_run = 0;
        else begin
          rx_wr = nxt;
          drv_nrfd = 0;
        end
      end
    end
    prev_nrfd = it.nrfd_line;
    prev_ndac = it.ndac_line;
    prev_dav = it.dav_line;
  endfunction

  function automatic gbhe_pkg::out_item_t predict_result(gbhe_pkg::in_item_t it);
    gbhe_pkg::out_item_t r;
    logic [2:0] st;
    r = '0;
    st = gbhe_pkg::ST_OK;
    r.end_seen = rx_end;
    case (it.action)
      gbhe_pkg::ACT_SAMPLE: bus_step(it, st);
      gbhe_pkg::ACT_PUSH, gbhe_pkg::ACT_PUSH_LAST: begin
        if (tx_end_pend || ring_inc(tx_wr) == tx_rd) st = gbhe_pkg::ST_TX_FULL;
        else begin
          tx_ring[tx_wr] = it.tx_byte;
          if (it.action == gbhe_pkg::ACT_PUSH_LAST) tx_end_pend = 1;
          tx_wr = ring_inc(tx_wr);
          if (mode_q == gbhe_pkg::MODE_TX && !tx_run) begin
            tx_run = 1;
            tx_wait_rdy = 1;
            if (!prev_nrfd) send_next_byte();
          end
        end
      end
      gbhe_pkg::ACT_POP: begin
        if (rx_rd == rx_wr) st = gbhe_pkg::ST_RX_EMPTY;
        else begin
          r.rx_byte = rx_ring[rx_rd];
          rx_rd = ring_inc(rx_rd);
          if (mode_q == gbhe_pkg::MODE_RX && !rx_run) begin
            // resume: a held byte gets committed first
            if (drv_nrfd) rx_wr = ring_inc(rx_wr);
            rx_run = 1;
            drv_nrfd = 0;
          end
        end
      end
      gbhe_pkg::ACT_TALK: begin
        if (mode_q != gbhe_pkg::MODE_TX) begin
          rx_run = 0; rx_wait_rel = 0;
          drv_dav = 0; drv_nrfd = 0; drv_ndac = 0; drv_eoi = 0;
          tx_wr = 0; tx_rd = 0;
          tx_end_pend = 0; tx_run = 0; tx_watch = 0; tx_wait_rdy = 1;
          mode_q = gbhe_pkg::MODE_TX;
        end
      end
      gbhe_pkg::ACT_LISTEN: begin
        if (mode_q != gbhe_pkg::MODE_RX) begin
          if (mode_q == gbhe_pkg::MODE_TX && (tx_rd != tx_wr || drv_dav))
            st = gbhe_pkg::ST_BUSY;
          else begin
            tx_run = 0; tx_watch = 0;
            release_talker();
            rx_wr = 0; rx_rd = 0;
            rx_end = 0; r.end_seen = 0;
            rx_wait_rel = 0; rx_run = 1;
            drv_nrfd = 0;
            mode_q = gbhe_pkg::MODE_RX;
          end
        end
      end
      gbhe_pkg::ACT_PASSIVE: begin
        tx_run = 0; tx_watch = 0; rx_run = 0; rx_wait_rel = 0;
        release_talker();
        mode_q = gbhe_pkg::MODE_PASSIVE;
      end
      default: rx_end = 0;
    endcase
    r.status = st;
    r.dav_drive = drv_dav;
    r.nrfd_drive = drv_nrfd;
    r.ndac_drive = drv_ndac;
    r.eoi_drive = drv_eoi;
    r.data_drive = (mode_q == gbhe_pkg::MODE_TX) ? drv_data : 8'd0;
    r.talking = (mode_q == gbhe_pkg::MODE_TX);
    r.tx_done = (tx_rd == tx_wr) && !drv_dav;
    r.rx_available = (rx_rd != rx_wr);
    r.mode = mode_q;
    return r;
  endfunction

  initial begin
    errors = 0;
    engine_reset();
  end

  always @(posedge clk) begin
    gbhe_pkg::out_item_t want, got;
    if (rst) begin
      engine_reset();
      expected_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = out_item;
        if (expected_q.size() == 0) begin
          $display("unexpected result beat at %0t", $realtime);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (got.status !== want.status) report("status", got.status, want.status);
          if (got.rx_byte !== want.rx_byte) report("rx_byte", got.rx_byte, want.rx_byte);
          if (got.end_seen !== want.end_seen)
            report("end_seen", got.end_seen, want.end_seen);
          if (got.dav_drive !== want.dav_drive)
            report("dav_drive", got.dav_drive, want.dav_drive);
          if (got.nrfd_drive !== want.nrfd_drive)
            report("nrfd_drive", got.nrfd_drive, want.nrfd_drive);
          if (got.ndac_drive !== want.ndac_drive)
            report("ndac_drive", got.ndac_drive, want.ndac_drive);
          if (got.eoi_drive !== want.eoi_drive)
            report("eoi_drive", got.eoi_drive, want.eoi_drive);
          if (got.data_drive !== want.data_drive)
            report("data_drive", got.data_drive, want.data_drive);
          if (got.talking !== want.talking) report("talking", got.talking, want.talking);
          if (got.tx_done !== want.tx_done) report("tx_done", got.tx_done, want.tx_done);
          if (got.rx_available !== want.rx_available)
            report("rx_available", got.rx_available, want.rx_available);
          if (got.mode !== want.mode) report("mode", got.mode, want.mode);
        end
      end
      if (in_valid && !in_stall) expected_q.push_back(predict_result(in_item));
    end
  end

endmodule

### tb/gpib_byte_handshake_engine_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpib_byte_handshake_engine_unit_tb
// drives host actions, bus samples and noise beats as directed steps and as talker and
// listener sessions with random gaps and stalls; the checker predicts and compares every result
// ----------------------------------------------------------------------------
module gpib_byte_handshake_engine_unit_tb;

  localparam int LIMIT_CYCLES = 200000;
  localparam int IN_W = $bits(gbhe_pkg::in_item_t);

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  gbhe_pkg::in_item_t  in_item;
  logic                out_valid;
  logic                out_stall;
  gbhe_pkg::out_item_t out_item;
  int                  errors;
  int                  pending;
  int                  cycles;
  logic                quiet;      // no idling in the last part
  logic                hold_long;  // receiver hold-off request

  gpib_byte_handshake_engine_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  gbhe_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // receiver: random stall bursts, plus one long hold-off
  initial begin
    int n;
    int k;
    out_stall = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_stall <= 1;
        for (k = 0; k < 60; k++) @(posedge clk);
        out_stall <= 0;
        wait (!hold_long);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 3);
        out_stall <= 1;
        for (k = 0; k < n; k++) @(posedge clk);
        out_stall <= 0;
      end
    end
  end

  function automatic gbhe_pkg::in_item_t rand_item();
    return gbhe_pkg::in_item_t'(IN_W'({$urandom(), $urandom()}));
  endfunction

  // offer one beat and wait until it is taken
  task automatic send_beat(gbhe_pkg::in_item_t it);
    int n;
    if (!quiet && $urandom_range(0, 6) == 0) begin
      n = $urandom_range(1, 3);
      in_valid <= 0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic host_op(logic [2:0] act, logic [7:0] b);
    gbhe_pkg::in_item_t it;
    it = rand_item();
    it.action = act;
    it.tx_byte = b;
    send_beat(it);
  endtask

  task automatic bus_beat(logic nrfd, logic ndac, logic dav, logic eoi, logic [7:0] d);
    gbhe_pkg::in_item_t it;
    it = rand_item();
    it.action = gbhe_pkg::ACT_SAMPLE;
    it.nrfd_line = nrfd;
    it.ndac_line = ndac;
    it.dav_line = dav;
    it.eoi_line = eoi;
    it.data_line = d;
    send_beat(it);
  endtask

  task automatic noise_beat();
    send_beat(rand_item());
  endtask

  // remote listener accepting one byte: ready, not ready, accepted, reset
  task automatic remote_accept();
    bus_beat(1, 1, 0, 0, 8'h00);
    bus_beat(0, 1, 0, 0, 8'h00);
    bus_beat(1, 1, 0, 0, 8'h00);
    bus_beat(1, 0, 0, 0, 8'h00);
    bus_beat(1, 1, 0, 0, 8'h00);
  endtask

  // remote talker sending one byte
  task automatic remote_send(logic [7:0] d, logic eoi);
    bus_beat(0, 0, 0, 0, d);
    bus_beat(0, 0, 1, eoi, d);
    bus_beat(0, 0, 0, 0, d);
  endtask

  task automatic talker_session();
    int n;
    int k;
    host_op(gbhe_pkg::ACT_TALK, 8'd0);
    n = $urandom_range(1, 6);
    for (k = 0; k < n; k++)
      host_op((k == n - 1) ? gbhe_pkg::ACT_PUSH_LAST : gbhe_pkg::ACT_PUSH, 8'($urandom()));
    for (k = 0; k < n + 1; k++) remote_accept();
    host_op(gbhe_pkg::ACT_LISTEN, 8'd0);
  endtask

  task automatic listener_session();
    int n;
    int k;
    host_op(gbhe_pkg::ACT_LISTEN, 8'd0);
    n = $urandom_range(1, 20);
    for (k = 0; k < n; k++) begin
      remote_send(8'($urandom()), (k == n - 1));
      if ($urandom_range(0, 2) == 0) host_op(gbhe_pkg::ACT_POP, 8'd0);
      if ($urandom_range(0, 9) == 0) bus_beat(0, 0, 1, 0, 8'($urandom()));  // early dav
    end
    host_op(gbhe_pkg::ACT_CLR_END, 8'd0);
    for (k = 0; k < 18; k++) host_op(gbhe_pkg::ACT_POP, 8'd0);
  endtask

  initial begin
    int k;
    int items;
    rst = 1;
    in_valid = 0;
    in_item = '0;
    quiet = 0;
    hold_long = 0;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: empty pop, pushes while passive, full ring, mode edges
    host_op(gbhe_pkg::ACT_POP, 8'd0);
    host_op(gbhe_pkg::ACT_PUSH, 8'h00);
    host_op(gbhe_pkg::ACT_PUSH, 8'hff);
    host_op(gbhe_pkg::ACT_LISTEN, 8'd0);
    host_op(gbhe_pkg::ACT_LISTEN, 8'd0);
    host_op(gbhe_pkg::ACT_CLR_END, 8'd0);
    host_op(gbhe_pkg::ACT_TALK, 8'd0);
    host_op(gbhe_pkg::ACT_TALK, 8'd0);
    for (k = 0; k < 17; k++) host_op(gbhe_pkg::ACT_PUSH, 8'(k * 15));
    host_op(gbhe_pkg::ACT_LISTEN, 8'd0);
    host_op(gbhe_pkg::ACT_PASSIVE, 8'd0);
    talker_session();

    // long receiver hold-off while beats keep coming
    hold_long = 1;
    for (k = 0; k < 30; k++) noise_beat();
    hold_long = 0;

    items = 0;
    while (items < 1250) begin
      k = $urandom_range(0, 9);
      if (k < 4) begin
        talker_session();
        items += 30;
      end else if (k < 8) begin
        listener_session();
        items += 50;
      end else begin
        repeat (10) noise_beat();
        host_op(gbhe_pkg::ACT_PASSIVE, 8'd0);
        items += 11;
      end
      if ($urandom_range(0, 7) == 0) begin
        // sender pauses until every result is in
        in_valid <= 0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
      end
      if (items > 1000) quiet = 1;
    end
    in_valid <= 0;
    @(posedge clk);
    wait (pending == 0);
    repeat (10) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
sv/gbhe_pkg.sv
sv/gbhe_ram.sv
sv/gbhe_front.sv
sv/gbhe_engine.sv
sv/gpib_byte_handshake_engine_unit.sv
tb/gbhe_checker.sv
tb/gpib_byte_handshake_engine_unit_tb.sv
